>>> sv/ees_pkg.sv
// Package: shared types and constants for the expected echo suppressor.
`timescale 1ns / 1ps
package ees_pkg;
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_PAT  = 2'd1;
	localparam logic [1:0] KIND_ARM  = 2'd2;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_TWO = 8'h32;
	localparam logic [7:0] CH_K   = 8'h4B;

	localparam logic [0:0] CFG_LEN    = 1'b0;
	localparam logic [0:0] CFG_BUDGET = 1'b1;

	// Command from the front part to the back part.
	typedef enum logic [1:0] {
		CMD_NONE,     // nothing to emit
		CMD_BYTE,     // emit one byte
		CMD_RELEASE,  // emit held bytes, then optional byte
		CMD_CLEAR     // emit CR ESC [ 2 K
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [5:0] count;  // held bytes to release
		logic       tail;   // a trailing byte follows the release
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REL,
		BK_TAIL,
		BK_CLR
	} bk_state_t;

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b < 8'h20) || (b == 8'h7F);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction
endpackage

>>> sv/ees_stream_if.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface ees_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] byte_value;
	logic [5:0] pattern_index;
	modport source(output valid, kind, byte_value, pattern_index, input ready);
	modport sink(input valid, kind, byte_value, pattern_index, output ready);
endinterface

interface ees_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	modport source(output valid, out_byte, last_of_run, input ready);
	modport sink(input valid, out_byte, last_of_run, output ready);
endinterface

>>> sv/ees_front.sv
// Front part: classifies input items, owns the match state and pattern store.
`timescale 1ns / 1ps
module ees_front #(
	parameter int PATTERN_DEPTH = 64,
	parameter int HOLD_DEPTH = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [7:0]        byte_value,
	input  logic [5:0]        pattern_index,
	input  logic [6:0]        pattern_length,
	input  logic [15:0]       budget_base,
	output logic              hold_we,
	output logic [5:0]        hold_waddr,
	output logic [7:0]        hold_wdata,
	output logic              cmd_push,
	output ees_pkg::cmd_t     cmd,
	input  logic              cmd_full
);
	import ees_pkg::*;

	localparam int PW = $clog2(PATTERN_DEPTH);

	logic [7:0]  pat_mem [PATTERN_DEPTH];
	logic [6:0]  hold_count_q, match_count_q;
	logic [16:0] budget_q;
	logic        await_q, esc_q, armed_q;

	// first pattern byte is kept in a register, the next expected byte is prefetched
	logic [7:0] pat_first_q, pat_cur_q;
	logic [6:0] len;
	logic       acc;
	logic       pat_we;

	always_comb begin
		if (pattern_length < 7'd2) len = 7'd2;
		else if (32'(pattern_length) > PATTERN_DEPTH) len = 7'(PATTERN_DEPTH);
		else len = pattern_length;
	end

	assign in_ready = !cmd_full;
	assign acc = in_valid && in_ready;
	assign pat_we = (kind == KIND_PAT) && (32'(pattern_index) < PATTERN_DEPTH);

	// next-state logic for one arm item or data byte
	logic [6:0]  hc_n, mc_n;
	logic [16:0] bud_n;
	logic        await_n, esc_n, armed_n;
	cmd_t        cmd_n;
	logic        hw;
	logic        full, mm, cm;

	always_comb begin
		hc_n = hold_count_q; mc_n = match_count_q; bud_n = budget_q;
		await_n = await_q; esc_n = esc_q; armed_n = armed_q;
		cmd_n = '{op: CMD_NONE, count: 6'd0, tail: 1'b0, data: byte_value};
		hw = 1'b0; mm = 1'b0;
		full = 32'(hold_count_q) >= HOLD_DEPTH;
		cm = (32'(match_count_q) < PATTERN_DEPTH) && byte_value == pat_cur_q;
		if (kind == KIND_ARM) begin
			bud_n = {7'd0, len, 3'd0} + {1'b0, budget_base};
			hc_n = '0; mc_n = '0; await_n = 1'b0; esc_n = 1'b0; armed_n = 1'b1;
		end else if (kind == KIND_DATA) begin
			if (!armed_q) begin
				cmd_n.op = CMD_BYTE;
			end else if (budget_q == '0) begin
				cmd_n = '{op: CMD_RELEASE, count: hold_count_q[5:0], tail: 1'b1,
					data: byte_value};
				armed_n = 1'b0; await_n = 1'b0; esc_n = 1'b0; mc_n = '0; hc_n = '0;
			end else begin
				bud_n = budget_q - 17'd1;
				if (await_q) begin
					if (byte_value == CH_LF) begin
						cmd_n.op = CMD_CLEAR;
						armed_n = 1'b0; await_n = 1'b0; esc_n = 1'b0; mc_n = '0; hc_n = '0;
					end else if (!is_ctrl(byte_value)) begin
						cmd_n.op = CMD_BYTE;
						armed_n = 1'b0; await_n = 1'b0; esc_n = 1'b0; mc_n = '0; hc_n = '0;
					end
				end else begin
					if (match_count_q != '0) begin
						mm = 1'b1;
						if (esc_q) begin
							if (!full) begin
								mm = 1'b0; hw = 1'b1; hc_n = hold_count_q + 7'd1;
								if (is_letter(byte_value) || byte_value == CH_TILDE)
									esc_n = 1'b0;
							end
						end else if (byte_value == CH_ESC) begin
							if (!full) begin
								mm = 1'b0; hw = 1'b1; hc_n = hold_count_q + 7'd1; esc_n = 1'b1;
							end
						end else if (cm) begin
							if (match_count_q + 7'd1 >= len) begin
								mm = 1'b0; hc_n = '0; mc_n = len; await_n = 1'b1;
							end else if (!full) begin
								mm = 1'b0; hw = 1'b1; hc_n = hold_count_q + 7'd1;
								mc_n = match_count_q + 7'd1;
							end
						end else if (is_ctrl(byte_value)) begin
							if (!full) begin
								mm = 1'b0; hw = 1'b1; hc_n = hold_count_q + 7'd1;
							end
						end
					end
					if (mm) begin
						// release held bytes, then re-examine
						cmd_n = '{op: CMD_RELEASE, count: hold_count_q[5:0], tail: 1'b1,
							data: byte_value};
						hc_n = '0; mc_n = '0; esc_n = 1'b0;
						if (bud_n == '0) begin
							armed_n = 1'b0; await_n = 1'b0;
						end else begin
							bud_n = bud_n - 17'd1;
							if (byte_value == pat_first_q) begin
								cmd_n.tail = 1'b0; hc_n = 7'd1; mc_n = 7'd1;
							end
						end
					end else if (match_count_q == '0) begin
						if (byte_value == pat_first_q) begin
							hw = 1'b1; hc_n = hold_count_q + 7'd1; mc_n = 7'd1;
						end else cmd_n.op = CMD_BYTE;
					end
					if (mm && cmd_n.count == '0 && !cmd_n.tail) cmd_n.op = CMD_NONE;
				end
			end
		end
	end

	// store pattern bytes, and prefetch the byte that the next match count compares against
	always_ff @(posedge clk) begin
		if (acc && pat_we) begin
			pat_mem[pattern_index[PW-1:0]] <= byte_value;
			if (pattern_index[PW-1:0] == '0) pat_first_q <= byte_value;
		end
		if (acc) begin
			if (pat_we && pattern_index[PW-1:0] == mc_n[PW-1:0]) pat_cur_q <= byte_value;
			else pat_cur_q <= pat_mem[mc_n[PW-1:0]];
		end
	end

	// re-held first byte lands at slot 0 after a release
	assign hold_we = acc && kind == KIND_DATA && (hw || (mm && hc_n == 7'd1));
	assign hold_waddr = mm ? 6'd0 : hold_count_q[5:0];
	assign hold_wdata = byte_value;
	assign cmd_push = acc && kind == KIND_DATA && cmd_n.op != CMD_NONE;
	assign cmd = cmd_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= '0; match_count_q <= '0; budget_q <= '0;
			await_q <= 1'b0; esc_q <= 1'b0; armed_q <= 1'b0;
		end else if (acc) begin
			hold_count_q <= hc_n; match_count_q <= mc_n; budget_q <= bud_n;
			await_q <= await_n; esc_q <= esc_n; armed_q <= armed_n;
		end
	end

`ifndef SYNTH
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hold_count_q) <= HOLD_DEPTH) else $error("hold count overflow");
	a_esc_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> match_count_q != '0) else $error("escape without match");
	a_await_armed: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> armed_q) else $error("awaiting newline while disarmed");
`endif
endmodule

>>> sv/ees_back.sv
// Back part: command queue, hold store and result sequencer.
`timescale 1ns / 1ps
module ees_back #(
	parameter int HOLD_DEPTH = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hold_we,
	input  logic [5:0]    hold_waddr,
	input  logic [7:0]    hold_wdata,
	input  logic          cmd_push,
	input  ees_pkg::cmd_t cmd,
	output logic          cmd_full,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          last_of_run
);
	import ees_pkg::*;

	// one-entry command queue: a release freezes the hold store until drained
	cmd_t       cq_q;
	logic       cq_v_q;
	bk_state_t  st_q, st_n;
	logic [5:0] idx_q;
	logic [2:0] clr_q;
	logic [7:0] hold_mem [HOLD_DEPTH];
	logic [7:0] rd_q;
	logic       done, take;

	assign cmd_full = cq_v_q;
	assign take = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (hold_we) hold_mem[hold_waddr] <= hold_wdata;
		// prefetch slot 0 while no command waits, then the next slot per released byte
		if (st_q == BK_IDLE && !cq_v_q) rd_q <= hold_mem[6'd0];
		else if (st_q == BK_REL && take && idx_q + 6'd1 != cq_q.count)
			rd_q <= hold_mem[idx_q + 6'd1];
	end

	always_comb begin
		st_n = st_q; done = 1'b0;
		unique case (st_q)
			BK_IDLE: if (cq_v_q) begin
				unique case (cq_q.op)
					CMD_BYTE: st_n = BK_TAIL;
					CMD_CLEAR: st_n = BK_CLR;
					CMD_RELEASE: st_n = (cq_q.count != '0) ? BK_REL : BK_TAIL;
					default: done = 1'b1;
				endcase
			end
			BK_REL: if (take && idx_q + 6'd1 == cq_q.count) begin
				if (cq_q.tail) st_n = BK_TAIL; else begin st_n = BK_IDLE; done = 1'b1; end
			end
			BK_TAIL: if (take) begin st_n = BK_IDLE; done = 1'b1; end
			BK_CLR: if (take && clr_q == 3'd4) begin st_n = BK_IDLE; done = 1'b1; end
			default: st_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE; cq_v_q <= 1'b0; idx_q <= '0; clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_n;
			if (cmd_push) cq_v_q <= 1'b1;
			else if (done) cq_v_q <= 1'b0;
			if (st_q == BK_IDLE) begin idx_q <= '0; clr_q <= '0; end
			if (take) begin
				out_valid <= 1'b0;
				unique case (st_q)
					BK_REL: begin
						out_valid <= 1'b1; out_byte <= rd_q;
						last_of_run <= !cq_q.tail && idx_q + 6'd1 == cq_q.count;
						idx_q <= idx_q + 6'd1;
					end
					BK_TAIL: begin
						out_valid <= 1'b1; out_byte <= cq_q.data; last_of_run <= 1'b1;
					end
					BK_CLR: begin
						out_valid <= 1'b1; last_of_run <= clr_q == 3'd4;
						unique case (clr_q)
							3'd0: out_byte <= CH_CR;
							3'd1: out_byte <= CH_ESC;
							3'd2: out_byte <= CH_LBR;
							3'd3: out_byte <= CH_TWO;
							default: out_byte <= CH_K;
						endcase
						clr_q <= clr_q + 3'd1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push) cq_q <= cmd;
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cq_v_q) else $error("push into full queue");
	a_busy_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != BK_IDLE |-> cq_v_q) else $error("sequencer busy without command");
	a_clr_range: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q <= 3'd5) else $error("clear sequence overrun");
`endif
endmodule

>>> sv/expected_echo_suppressor_core.sv
// Top level: expected echo suppressor with configuration registers.
//  channel | dir | payload
//  in_ch   | in  | kind, byte_value, pattern_index
//  out_ch  | out | out_byte, last_of_run
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// An item is taken when the command slot is free; items that emit bytes occupy
// the slot until the sequencer drains them, one byte per cycle while out_ch is ready.
// A passed byte, the CR ESC [ 2 K run and a release of held bytes with its optional
// trailing byte all block input until drained; output stalls lengthen the block.
// Reset: asynchronous active low clears control state; stores are undefined.
// Output is registered and stalls freely on ready.
`timescale 1ns / 1ps
module expected_echo_suppressor_core #(
	parameter int PATTERN_DEPTH = 64,
	parameter int HOLD_DEPTH = 63
) (
	input logic        clk,
	input logic        arst_n,
	ees_in_if.sink     in_ch,
	ees_out_if.source  out_ch,
	input logic        cfg_we,
	input logic [0:0]  cfg_index,
	input logic [15:0] cfg_data
);
	import ees_pkg::*;

	logic [6:0]  len_q;
	logic [15:0] base_q;
	logic        hold_we, cmd_push, cmd_full;
	logic [5:0]  hold_waddr;
	logic [7:0]  hold_wdata;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 7'd2; base_q <= 16'd8192;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEN: len_q <= cfg_data[6:0];
				default: base_q <= cfg_data;
			endcase
		end
	end

	ees_front #(.PATTERN_DEPTH(PATTERN_DEPTH), .HOLD_DEPTH(HOLD_DEPTH)) u_front (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.kind(in_ch.kind), .byte_value(in_ch.byte_value),
		.pattern_index(in_ch.pattern_index), .pattern_length(len_q),
		.budget_base(base_q), .hold_we, .hold_waddr, .hold_wdata,
		.cmd_push, .cmd, .cmd_full);

	ees_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
		.clk, .arst_n, .hold_we, .hold_waddr, .hold_wdata, .cmd_push, .cmd,
		.cmd_full, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_byte(out_ch.out_byte), .last_of_run(out_ch.last_of_run));
endmodule
